// ----- hw/rtl/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg
// shared constants, types and the cordic angle table of the rotate block
// ----------------------------------------------------------------------------
`default_nettype none
package mer_pkg;
	localparam int ELEM_W         = 32;
	localparam int ANG_W          = 19;
	localparam int ELEM_FRAC_DEF  = 16;
	localparam int CORDIC_DEF     = 16;
	localparam int TABLE_LEN      = 31;
	localparam int Z_W            = 33;
	localparam int XY_W           = 34;
	localparam int SC_FRAC        = 30;
	localparam logic signed [ANG_W-1:0] ANG_LIMIT = 19'sd205887;
	localparam logic signed [Z_W-1:0] HALF_PI_Q29 = 33'sd843314857;
	localparam logic signed [Z_W-1:0] PI_Q29      = 33'sd1686629713;
	localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032874;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   flip;
		logic                   skip;
	} cstate_t;

	function automatic logic signed [Z_W-1:0] atan_q29(input int i);
		logic signed [Z_W-1:0] r;
		r = '0;
		case (i)
			0: r = 33'sd421657428;
			1: r = 33'sd248918915;
			2: r = 33'sd131521918;
			3: r = 33'sd66762579;
			4: r = 33'sd33510843;
			5: r = 33'sd16771758;
			6: r = 33'sd8387925;
			7: r = 33'sd4194219;
			8: r = 33'sd2097141;
			9: r = 33'sd1048575;
			default: begin
				if (i < 30) r = Z_W'(64'sd1 << (29 - i));
				else r = '0;
			end
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/mer_cordic.sv -----
// ----------------------------------------------------------------------------
// mer_cordic
// pipelined rotation-mode cordic, one step per stage, plus entry fold stage
// ----------------------------------------------------------------------------
`default_nettype none
module mer_cordic
	import mer_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_DEF
) (
	input  wire                          clk,
	input  wire                          en,
	input  wire logic signed [ANG_W-1:0] angle,
	input  wire                          negate,
	output cstate_t                      res
);
	localparam int N = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

	cstate_t st_s1 [N+1];
	logic signed [ANG_W:0] a;
	logic signed [Z_W-1:0] z0;
	cstate_t ent;

	always_comb begin
		a = negate ? -{angle[ANG_W-1], angle} : {angle[ANG_W-1], angle};
		if (a > (ANG_W+1)'(ANG_LIMIT)) a = (ANG_W+1)'(ANG_LIMIT);
		if (a < -(ANG_W+1)'(ANG_LIMIT)) a = -(ANG_W+1)'(ANG_LIMIT);
		z0 = Z_W'(a) <<< 13;
		ent.flip = 1'b0;
		if (z0 > HALF_PI_Q29) begin
			z0 = z0 - PI_Q29;
			ent.flip = 1'b1;
		end else if (z0 < -HALF_PI_Q29) begin
			z0 = z0 + PI_Q29;
			ent.flip = 1'b1;
		end
		ent.x = GAIN_Q30;
		ent.y = '0;
		ent.z = z0;
		ent.skip = (angle == '0);
	end

	always_ff @(posedge clk) begin
		if (en) st_s1[0] <= ent;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				st_s1[i+1].flip <= st_s1[i].flip;
				st_s1[i+1].skip <= st_s1[i].skip;
				if (st_s1[i].z >= 0) begin
					st_s1[i+1].x <= st_s1[i].x - (st_s1[i].y >>> i);
					st_s1[i+1].y <= st_s1[i].y + (st_s1[i].x >>> i);
					st_s1[i+1].z <= st_s1[i].z - atan_q29(i);
				end else begin
					st_s1[i+1].x <= st_s1[i].x + (st_s1[i].y >>> i);
					st_s1[i+1].y <= st_s1[i].y - (st_s1[i].x >>> i);
					st_s1[i+1].z <= st_s1[i].z + atan_q29(i);
				end
			end
		end
	end

	always_comb begin
		res = st_s1[N];
		if (st_s1[N].flip) begin
			res.x = -st_s1[N].x;
			res.y = -st_s1[N].y;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/mer_turn.sv -----
// ----------------------------------------------------------------------------
// mer_turn
// rotates one element pair: product stage, then sum, round and saturate
// ----------------------------------------------------------------------------
`default_nettype none
module mer_turn
	import mer_pkg::*;
(
	input  wire          clk,
	input  wire          en,
	input  wire cstate_t sc,
	input  wire elem_t   a,
	input  wire elem_t   b,
	output elem_t        a_o,
	output elem_t        b_o
);
	localparam int P_W = ELEM_W + XY_W;
	localparam int S_W = P_W + 1;

	logic signed [P_W-1:0] ac_s1, bs_s1, as_s1, bc_s1;
	logic skip_s1;
	elem_t a_s1, b_s1, a_s2, b_s2;
	logic signed [S_W-1:0] sa, sb;

	always_ff @(posedge clk) begin
		if (en) begin
			ac_s1 <= P_W'(a) * P_W'(sc.x);
			bs_s1 <= P_W'(b) * P_W'(sc.y);
			as_s1 <= P_W'(a) * P_W'(sc.y);
			bc_s1 <= P_W'(b) * P_W'(sc.x);
			skip_s1 <= sc.skip;
			a_s1 <= a;
			b_s1 <= b;
		end
	end

	function automatic elem_t rsat(input logic signed [S_W-1:0] v);
		logic signed [S_W-1:0] r;
		r = (v + (S_W'(1) <<< (SC_FRAC - 1))) >>> SC_FRAC;
		if (r > S_W'(32'sh7fffffff)) return 32'sh7fffffff;
		if (r < -S_W'(64'sd2147483648)) return 32'sh80000000;
		return r[ELEM_W-1:0];
	endfunction

	always_comb begin
		sa = S_W'(ac_s1) - S_W'(bs_s1);
		sb = S_W'(as_s1) + S_W'(bc_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= skip_s1 ? a_s1 : rsat(sa);
			b_s2 <= skip_s1 ? b_s1 : rsat(sb);
		end
	end

	assign a_o = a_s2;
	assign b_o = b_s2;
endmodule
`default_nettype wire

// ----- hw/rtl/matrix_euler_rotate.sv -----
// ----------------------------------------------------------------------------
// matrix_euler_rotate
// rotates the 3x3 part of a 4x4 transform by x, y then z euler angles
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready carry nine elements and three angles;
// output channel: out_valid/out_ready carry the nine rotated elements.
// one transfer per cycle on both sides while the output is not stalled.
// sine and cosine for all three angles come from three cordic pipelines of
// CORDIC_STEPS+1 stages (steps capped at TABLE_LEN) that start together;
// the z and y data then wait in delay lines while the x, y and z turn
// stages (two stages each) run in series.
// the whole pipe advances together: when out_valid is high and out_ready
// low, the pipe holds and in_ready drops; nothing is lost or repeated.
// reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix_euler_rotate
	import mer_pkg::*;
#(
	parameter int ELEM_FRAC_BITS = ELEM_FRAC_DEF,
	parameter int CORDIC_STEPS   = CORDIC_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire elem_t                   in_m0, in_m1, in_m2, in_m4, in_m5, in_m6,
	input  wire elem_t                   in_m8, in_m9, in_m10,
	input  wire logic signed [ANG_W-1:0] angle_x, angle_y, angle_z,
	output logic                         out_valid,
	input  wire                          out_ready,
	output elem_t                        out_m0, out_m1, out_m2, out_m4, out_m5,
	output elem_t                        out_m6, out_m8, out_m9, out_m10
);
	localparam int N   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int CL  = N + 1;
	localparam int LAT = CL + 6;

	logic en;
	logic [LAT-1:0] vld_s1;
	cstate_t scx, scy, scz;
	cstate_t scy_d_s1 [2];
	cstate_t scz_d_s1 [4];
	elem_t e_s1 [CL][9];
	elem_t x4, x5, x6, x8, x9, x10;
	elem_t y0, y1, y2, y8, y9, y10;
	elem_t z0, z1, z2, z4, z5, z6;
	elem_t d0_s1 [2], d1_s1 [2], d2_s1 [2];
	elem_t e8_s1 [2], e9_s1 [2], e10_s1 [2];
	elem_t f4_s1 [2], f5_s1 [2], f6_s1 [2];

	assign en = ~out_valid | out_ready;
	assign in_ready = en;
	assign out_valid = vld_s1[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
		end else if (en) begin
			vld_s1 <= {vld_s1[LAT-2:0], in_valid};
		end
	end

	mer_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cx (.clk, .en,
		.angle(angle_x), .negate(1'b1), .res(scx));
	mer_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cy (.clk, .en,
		.angle(angle_y), .negate(1'b0), .res(scy));
	mer_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cz (.clk, .en,
		.angle(angle_z), .negate(1'b1), .res(scz));

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1[0] <= '{in_m0, in_m1, in_m2, in_m4, in_m5, in_m6, in_m8, in_m9, in_m10};
			for (int i = 1; i < CL; i++) e_s1[i] <= e_s1[i-1];
			scy_d_s1[0] <= scy;
			scy_d_s1[1] <= scy_d_s1[0];
			scz_d_s1[0] <= scz;
			for (int i = 1; i < 4; i++) scz_d_s1[i] <= scz_d_s1[i-1];
			d0_s1[0] <= e_s1[CL-1][0];
			d1_s1[0] <= e_s1[CL-1][1];
			d2_s1[0] <= e_s1[CL-1][2];
			d0_s1[1] <= d0_s1[0];
			d1_s1[1] <= d1_s1[0];
			d2_s1[1] <= d2_s1[0];
			f4_s1[0] <= x4;
			f5_s1[0] <= x5;
			f6_s1[0] <= x6;
			f4_s1[1] <= f4_s1[0];
			f5_s1[1] <= f5_s1[0];
			f6_s1[1] <= f6_s1[0];
			e8_s1[0] <= y8;
			e9_s1[0] <= y9;
			e10_s1[0] <= y10;
			e8_s1[1] <= e8_s1[0];
			e9_s1[1] <= e9_s1[0];
			e10_s1[1] <= e10_s1[0];
		end
	end

	// pass x
	mer_turn u_x0 (.clk, .en, .sc(scx), .a(e_s1[CL-1][3]), .b(e_s1[CL-1][6]),
		.a_o(x4), .b_o(x8));
	mer_turn u_x1 (.clk, .en, .sc(scx), .a(e_s1[CL-1][4]), .b(e_s1[CL-1][7]),
		.a_o(x5), .b_o(x9));
	mer_turn u_x2 (.clk, .en, .sc(scx), .a(e_s1[CL-1][5]), .b(e_s1[CL-1][8]),
		.a_o(x6), .b_o(x10));

	// pass y
	mer_turn u_y0 (.clk, .en, .sc(scy_d_s1[1]), .a(d0_s1[1]), .b(x8),
		.a_o(y0), .b_o(y8));
	mer_turn u_y1 (.clk, .en, .sc(scy_d_s1[1]), .a(d1_s1[1]), .b(x9),
		.a_o(y1), .b_o(y9));
	mer_turn u_y2 (.clk, .en, .sc(scy_d_s1[1]), .a(d2_s1[1]), .b(x10),
		.a_o(y2), .b_o(y10));

	// pass z
	mer_turn u_z0 (.clk, .en, .sc(scz_d_s1[3]), .a(y0), .b(f4_s1[1]),
		.a_o(z0), .b_o(z4));
	mer_turn u_z1 (.clk, .en, .sc(scz_d_s1[3]), .a(y1), .b(f5_s1[1]),
		.a_o(z1), .b_o(z5));
	mer_turn u_z2 (.clk, .en, .sc(scz_d_s1[3]), .a(y2), .b(f6_s1[1]),
		.a_o(z2), .b_o(z6));

	assign out_m0 = z0;
	assign out_m1 = z1;
	assign out_m2 = z2;
	assign out_m4 = z4;
	assign out_m5 = z5;
	assign out_m6 = z6;
	assign out_m8 = e8_s1[1];
	assign out_m9 = e9_s1[1];
	assign out_m10 = e10_s1[1];

	localparam int UNUSED_FRAC = ELEM_FRAC_BITS;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1)) else $error("valid bits moved during stall");
	a_ready_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
	a_pipe_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_valid) |=> vld_s1[0]) else $error("accepted item lost");
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// drives matrices and euler angles into the rotate block at random rates and
// compares every rotated matrix with a bit-exact cordic and fixed-point
// model kept in a small scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import mer_pkg::*;

	typedef logic signed [ANG_W-1:0] ang_t;

	typedef struct {
		elem_t m [9];
	} mat_t;

	class rotation_scoreboard;
		mat_t pending_mats [$];
		int   errors;

		static function longint floor_shr(longint v, int k);
			return v >>> k;
		endfunction

		static function void sin_cos(longint ang, output longint s, output longint c);
			longint z, x, y, nx;
			bit     flip;
			x = GAIN_Q30;
			y = 0;
			flip = 0;
			if (ang > ANG_LIMIT) ang = ANG_LIMIT;
			if (ang < -ANG_LIMIT) ang = -ANG_LIMIT;
			z = ang * 8192;
			if (z > HALF_PI_Q29) begin
				z -= PI_Q29;
				flip = 1;
			end else if (z < -HALF_PI_Q29) begin
				z += PI_Q29;
				flip = 1;
			end
			for (int i = 0; i < CORDIC_DEF && i < TABLE_LEN; i++) begin
				if (z >= 0) begin
					nx = x - floor_shr(y, i);
					y = y + floor_shr(x, i);
					z -= atan_q29(i);
				end else begin
					nx = x + floor_shr(y, i);
					y = y - floor_shr(x, i);
					z += atan_q29(i);
				end
				x = nx;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			s = y;
			c = x;
		endfunction

		static function longint round_sat(longint acc);
			longint r;
			r = (acc + (64'sd1 <<< (SC_FRAC - 1))) >>> SC_FRAC;
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r;
		endfunction

		static function void turn(ref longint e [9], input longint ang,
				input int a0, input int b0);
			longint s, c, a, b;
			sin_cos(ang, s, c);
			for (int k = 0; k < 3; k++) begin
				a = e[a0 + k];
				b = e[b0 + k];
				e[a0 + k] = round_sat(a * c - b * s);
				e[b0 + k] = round_sat(a * s + b * c);
			end
		endfunction

		function void note_input(mat_t mi, ang_t ax, ang_t ay, ang_t az);
			longint e [9];
			mat_t   r;
			for (int k = 0; k < 9; k++) e[k] = mi.m[k];
			if (ax != 0) turn(e, -longint'(ax), 3, 6);
			if (ay != 0) turn(e, longint'(ay), 0, 6);
			if (az != 0) turn(e, -longint'(az), 0, 3);
			for (int k = 0; k < 9; k++) r.m[k] = elem_t'(e[k]);
			pending_mats.push_back(r);
		endfunction

		function void check_result(elem_t got [9]);
			mat_t want;
			if (pending_mats.size() == 0) begin
				$display("%0t unexpected result", $realtime);
				errors++;
				return;
			end
			want = pending_mats.pop_front();
			for (int k = 0; k < 9; k++)
				if (got[k] !== want.m[k]) begin
					$display("%0t slot %0d expected %0d actual %0d", $realtime, k,
						want.m[k], got[k]);
					errors++;
				end
		endfunction
	endclass

	logic  clk = 0;
	logic  arst_n = 0;
	logic  in_valid = 0;
	logic  in_ready;
	elem_t in_m [9];
	ang_t  angle_x = 0, angle_y = 0, angle_z = 0;
	logic  out_valid;
	logic  out_ready = 0;
	elem_t out_m [9];
	int    quiet_cycles = 0;
	bit    calm = 0;
	bit    feeding_done = 0;

	rotation_scoreboard board = new();

	initial foreach (in_m[k]) in_m[k] = '0;

	always #2 clk = ~clk;

	matrix_euler_rotate dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_m0(in_m[0]), .in_m1(in_m[1]), .in_m2(in_m[2]),
		.in_m4(in_m[3]), .in_m5(in_m[4]), .in_m6(in_m[5]),
		.in_m8(in_m[6]), .in_m9(in_m[7]), .in_m10(in_m[8]),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_m0(out_m[0]), .out_m1(out_m[1]), .out_m2(out_m[2]),
		.out_m4(out_m[3]), .out_m5(out_m[4]), .out_m6(out_m[5]),
		.out_m8(out_m[6]), .out_m9(out_m[7]), .out_m10(out_m[8])
	);

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 5))
			0: return elem_t'($urandom);
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return elem_t'($urandom_range(0, 131072)) - 32'sd65536;
			default: return elem_t'($signed($urandom) >>> $urandom_range(0, 16));
		endcase
	endfunction

	function automatic ang_t rand_ang();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ang_t'($urandom);
			2: return ($urandom_range(0, 1)) ? ANG_LIMIT : -ANG_LIMIT;
			3: return ang_t'($urandom_range(0, 8)) - 19'sd4;
			default: return ang_t'($urandom_range(0, 2 * 205887)) - ANG_LIMIT;
		endcase
	endfunction

	task automatic send(mat_t mi, ang_t ax, ang_t ay, ang_t az);
		while (!calm && $urandom_range(0, 99) < 22) begin
			in_valid <= 0;
			@(posedge clk);
		end
		foreach (in_m[k]) in_m[k] <= mi.m[k];
		angle_x <= ax;
		angle_y <= ay;
		angle_z <= az;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		board.note_input(mi, ax, ay, az);
	endtask

	task automatic send_rand(ang_t ax, ang_t ay, ang_t az);
		mat_t mi;
		foreach (mi.m[k]) mi.m[k] = rand_elem();
		send(mi, ax, ay, az);
	endtask

	initial begin
		mat_t mi;
		ang_t edge_angs [8];
		edge_angs = '{19'sd0, 19'sd205887, -19'sd205887, 19'sh3ffff, 19'sh40000,
			19'sd102944, -19'sd102944, 19'sd1};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (mi.m[k]) mi.m[k] = (k % 4 == 0) ? 32'sd65536 : 32'sd0;
		send(mi, '0, '0, '0);
		foreach (edge_angs[i]) begin
			send(mi, edge_angs[i], '0, '0);
			send(mi, '0, edge_angs[i], '0);
			send(mi, '0, '0, edge_angs[i]);
		end
		foreach (mi.m[k]) mi.m[k] = (k % 2) ? 32'sh7fffffff : 32'sh80000000;
		send(mi, 19'sd51472, 19'sd51472, 19'sd51472);
		for (int n = 0; n < 1250; n++) begin
			calm = (n >= 500 && n < 700);
			send_rand(rand_ang(), rand_ang(), rand_ang());
		end
		in_valid <= 0;
		calm = 0;
		feeding_done = 1;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) board.check_result(out_m);
		out_ready <= calm || ($urandom_range(0, 99) >= 22);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 2000) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		wait (feeding_done);
		while (board.pending_mats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && !out_valid) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
